[rtl/breathing_alpha_envelope_assert.svh]
// assertion macros for the breathing alpha envelope
`ifndef BREATHING_ALPHA_ENVELOPE_ASSERT_SVH
`define BREATHING_ALPHA_ENVELOPE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BAE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("breathing_alpha_envelope: check failed");

// next-cycle implication, checked out of reset
`define BAE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("breathing_alpha_envelope: check failed");

`endif

[rtl/bae_pkg.sv]
// shared widths, register indexes and defaults of the breathing alpha envelope
package bae_pkg;

  localparam int unsigned PHASE_BITS_DEF = 10;

  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned PERIOD_W  = 32;
  localparam int unsigned ALPHA_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned MAG_W     = 8;
  localparam int unsigned LEVEL_W   = 9;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd10000;
  localparam logic [ALPHA_W-1:0]  PEAK_RESET   = 8'd0;
  localparam logic [MAG_W-1:0]    MAG_MAX      = 8'd128;
  localparam logic [LEVEL_W-1:0]  LEVEL_MID    = 9'd128;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_ALPHA = 2'd1;

endpackage

[rtl/bae_level_rom.sv]
// quarter-wave cosine table with registered read, folded to the envelope level
module bae_level_rom
  import bae_pkg::*;
#(
  parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rd_en_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  output logic [LEVEL_W-1:0]    level_o
);

  localparam int unsigned QSTEPS = 1 << (PHASE_BITS - 2);
  localparam int unsigned IDX_W  = PHASE_BITS - 1;
  localparam logic [63:0] Q62_ONE     = 64'h4000000000000000;
  localparam logic [63:0] Q62_HALF_PI = 64'h6487ED5110B4611A;

  typedef logic [MAG_W-1:0] mag_tab_t [QSTEPS+1];

  // floor(a * b / 2^62)
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // restoring long division for the table build
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cos or sin of an angle in 0..pi/4, Q2.62 taylor series
  function automatic logic [63:0] series_q62(input logic [63:0] x, input logic is_sine);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] total;
    logic [63:0] d;
    x2    = mul_q62(x, x);
    term  = is_sine ? x : Q62_ONE;
    total = term;
    for (int n = 1; n <= 24; n++) begin
      if (term != 64'd0) begin
        d = is_sine ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
        term = div_u64(mul_q62(term, x2), d);
        if (n[0]) begin
          total = total - term;
        end else begin
          total = total + term;
        end
      end
    end
    return total;
  endfunction

  function automatic logic [MAG_W-1:0] quarter_mag(input int unsigned r);
    logic [63:0] frac;
    logic [63:0] c;
    if (r <= (QSTEPS >> 1)) begin
      frac = 64'(r) << (62 - (PHASE_BITS - 2));
      c    = series_q62(mul_q62(Q62_HALF_PI, frac), 1'b0);
    end else begin
      frac = 64'(QSTEPS - r) << (62 - (PHASE_BITS - 2));
      c    = series_q62(mul_q62(Q62_HALF_PI, frac), 1'b1);
    end
    return c[62:55];
  endfunction

  function automatic mag_tab_t build_mag_tab();
    mag_tab_t t;
    for (int unsigned r = 0; r <= QSTEPS; r++) begin
      t[r] = quarter_mag(r);
    end
    return t;
  endfunction

  localparam mag_tab_t MagTab = build_mag_tab();

  logic [1:0]       quad;
  logic [IDX_W-1:0] r_idx;
  logic [IDX_W-1:0] rom_idx;
  logic [MAG_W-1:0] mag_q;
  logic [1:0]       quad_q;
  logic [MAG_W-1:0] mag_clip;

  assign quad    = phase_i[PHASE_BITS-1 -: 2];
  assign r_idx   = {1'b0, phase_i[PHASE_BITS-3:0]};
  assign rom_idx = quad[0] ? (IDX_W'(QSTEPS) - r_idx) : r_idx;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mag_q  <= MagTab[rom_idx];
      quad_q <= quad;
    end
  end

  assign mag_clip = (mag_q > MAG_MAX) ? MAG_MAX : mag_q;

  always_comb begin
    if (quad_q == 2'd0 || quad_q == 2'd3) begin
      level_o = LEVEL_MID - LEVEL_W'(mag_clip);
    end else begin
      level_o = LEVEL_MID + LEVEL_W'(mag_clip);
    end
  end

endmodule

[rtl/breathing_alpha_envelope.sv]
// top level of the breathing alpha envelope: position modulo, phase divide, table, scale
// a request runs through ST_MOD, ST_PHASE and ST_LOOK to ST_OUT, which waits until the output
// register is empty or not stalled; only one request is in flight at a time, as the
// shared 33-bit subtract unit runs 33 modulo steps then PHASE_BITS phase steps for it
// the next request is taken while an earlier result still waits in the output register
// reset: period 10000 ms, peak 0, position 0, no result pending; no clearing pass
`include "breathing_alpha_envelope_assert.svh"

module breathing_alpha_envelope
  import bae_pkg::*;
#(
  parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ELAPSED_W-1:0] elapsed_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ALPHA_W-1:0]   alpha_o
);

  localparam int unsigned DIV_W     = PERIOD_W + 1;
  localparam int unsigned MOD_STEPS = DIV_W;
  localparam int unsigned CNT_W     = $clog2(MOD_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_PHASE,
    ST_LOOK,
    ST_OUT
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [PERIOD_W-1:0]   period_q;
  logic [ALPHA_W-1:0]    peak_q;
  logic [PERIOD_W-1:0]   pos_q;
  logic [DIV_W-1:0]      div_q;
  logic [PERIOD_W-1:0]   rem_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic                  out_valid_q;
  logic [ALPHA_W-1:0]    alpha_q;

  logic                  in_fire;
  logic                  out_fire;
  logic                  out_load;
  logic                  step_bit;
  logic [DIV_W-1:0]      trial;
  logic [DIV_W:0]        diff;
  logic                  ge;
  logic [PERIOD_W-1:0]   rem_d;
  logic [LEVEL_W-1:0]    level;
  logic [ALPHA_W+LEVEL_W-1:0] prod;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign alpha_o     = alpha_q;

  // shared restoring subtract step
  assign step_bit = (state_q == ST_MOD) ? div_q[DIV_W-1] : 1'b0;
  assign trial    = {rem_q, step_bit};
  assign diff     = {1'b0, trial} - {2'b00, period_q};
  assign ge       = !diff[DIV_W];
  assign rem_d    = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];

  bae_level_rom #(
    .PHASE_BITS(PHASE_BITS)
  ) u_level_rom (
    .clk_i   (clk_i),
    .rd_en_i (state_q == ST_LOOK),
    .phase_i (phase_q),
    .level_o (level)
  );

  assign prod = {{LEVEL_W{1'b0}}, peak_q} * {{ALPHA_W{1'b0}}, level};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RESET;
      peak_q      <= PEAK_RESET;
      pos_q       <= '0;
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      div_q       <= '0;
      rem_q       <= '0;
      phase_q     <= '0;
      alpha_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PERIOD_MS: begin
            if (cfg_wdata_i[PERIOD_W-1:0] != '0) begin
              period_q <= cfg_wdata_i[PERIOD_W-1:0];
            end
          end
          REG_PEAK_ALPHA: begin
            peak_q <= cfg_wdata_i[ALPHA_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            div_q   <= {1'b0, pos_q} + DIV_W'(elapsed_ms_i);
            rem_q   <= '0;
            cnt_q   <= CNT_W'(MOD_STEPS - 1);
            state_q <= ST_MOD;
          end
        end
        ST_MOD: begin
          rem_q <= rem_d;
          div_q <= {div_q[DIV_W-2:0], 1'b0};
          if (cnt_q == '0) begin
            pos_q   <= rem_d;
            cnt_q   <= CNT_W'(PHASE_BITS - 1);
            state_q <= ST_PHASE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_PHASE: begin
          rem_q   <= rem_d;
          phase_q <= {phase_q[PHASE_BITS-2:0], ge};
          cnt_q   <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            alpha_q <= prod[ALPHA_W+LEVEL_W-2 -: ALPHA_W];
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `BAE_ASSERT_NEXT(a_pos_in_period, (state_q == ST_MOD) && (cnt_q == '0), pos_q < period_q)
  `BAE_ASSERT_NOW(a_rem_in_period, state_q == ST_PHASE, rem_q < period_q)
  `BAE_ASSERT_NOW(a_level_range, state_q == ST_OUT, !level[LEVEL_W-1] || (level[LEVEL_W-2:0] == '0))

endmodule

[bench/tb_breathing_alpha_envelope.sv]
// testbench for the breathing alpha envelope: directed table, then random frame ticks
`timescale 1ns / 1ps

module tb_breathing_alpha_envelope;
  import bae_pkg::*;

  localparam int unsigned PHASE_W = PHASE_BITS_DEF;
  localparam int unsigned QUARTER = 1 << (PHASE_W - 2);
  localparam real HALF_PI = 1.5707963267948966;
  localparam int unsigned PHASES = 10;
  localparam int unsigned TICKS_PER_PHASE = 150;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum logic {
    ROW_WRITE,
    ROW_TICK
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DW-1:0] data;
    logic [ELAPSED_W-1:0] elapsed;
    logic known;
    logic [ALPHA_W-1:0] alpha;
  } stim_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_HOLD
  } stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ELAPSED_W-1:0] elapsed_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ALPHA_W-1:0] alpha;

  logic [PERIOD_W-1:0] period_m = PERIOD_RESET;
  logic [ALPHA_W-1:0] peak_m = PEAK_RESET;
  logic [PERIOD_W-1:0] position_m = '0;

  logic [ALPHA_W-1:0] alpha_q[$];
  stim_row_t stim_table[$];
  int mismatch_count = 0;
  logic [ALPHA_W-1:0] want_alpha;

  stall_mode_e stall_mode = STALL_NONE;
  int stall_left = 0;

  breathing_alpha_envelope dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .elapsed_ms_i(elapsed_ms),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .alpha_o     (alpha)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // raised cosine level 0..256 for one phase step
  function automatic logic [LEVEL_W-1:0] raised_level(input logic [PHASE_W-1:0] phase);
    int quad;
    int steps;
    int mag;
    quad = phase >> (PHASE_W - 2);
    steps = phase % QUARTER;
    if (quad == 1 || quad == 3) steps = QUARTER - steps;
    mag = $rtoi(128.0 * $cos(HALF_PI * steps / QUARTER));
    if (mag > MAG_MAX) mag = MAG_MAX;
    if (quad == 0 || quad == 3) return LEVEL_W'(LEVEL_MID - mag);
    return LEVEL_W'(LEVEL_MID + mag);
  endfunction

  function automatic logic [ALPHA_W-1:0] advance_envelope(input logic [ELAPSED_W-1:0] e);
    logic [PERIOD_W:0] sum;
    logic [PERIOD_W+PHASE_W-1:0] scaled;
    logic [ALPHA_W+LEVEL_W-1:0] prod;
    sum = position_m + e;
    sum = sum % period_m;
    position_m = sum[PERIOD_W-1:0];
    scaled = {position_m, {PHASE_W{1'b0}}};
    scaled = scaled / period_m;
    prod = peak_m * raised_level(scaled[PHASE_W-1:0]);
    return prod[ALPHA_W+LEVEL_W-2 -: ALPHA_W];
  endfunction

  function automatic void row_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DW-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    stim_table.push_back(r);
  endfunction

  function automatic void row_tick(input logic [ELAPSED_W-1:0] e, input logic known,
                                   input logic [ALPHA_W-1:0] a);
    stim_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.elapsed = e;
    r.known = known;
    r.alpha = a;
    stim_table.push_back(r);
  endfunction

  function automatic logic [ELAPSED_W-1:0] random_elapsed();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return ELAPSED_W'($urandom_range(0, 16));
      2: return ELAPSED_W'($urandom_range(0, 300));
      3: return '1;
      default: return ELAPSED_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] random_period();
    case ($urandom_range(0, 5))
      0: return CFG_DW'($urandom_range(1, 8));
      1: return CFG_DW'($urandom_range(1, 1500));
      2: return CFG_DW'($urandom_range(1000, 70000));
      3: return $urandom();
      4: return '1;
      default: return '0;
    endcase
  endfunction

  task automatic send_tick(input logic [ELAPSED_W-1:0] e, input logic known,
                           input logic [ALPHA_W-1:0] a);
    logic [ALPHA_W-1:0] predicted;
    in_valid <= 1'b1;
    elapsed_ms <= e;
    do @(posedge clk_i); while (in_stall);
    predicted = advance_envelope(e);
    alpha_q.push_back(known ? a : predicted);
  endtask

  task automatic park_and_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (alpha_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_PERIOD_MS: if (data != '0) period_m = data[PERIOD_W-1:0];
      REG_PEAK_ALPHA: peak_m = data[ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (alpha_q.size() == 0) begin
        report_mismatch($sformatf("alpha %0d with no request pending", alpha));
      end else begin
        want_alpha = alpha_q.pop_front();
        if (alpha !== want_alpha)
          report_mismatch($sformatf("alpha %0d, want %0d", alpha, want_alpha));
      end
    end
  end

  initial begin
    int sent;
    int burst;
    row_tick(16'd0, 1'b1, 8'd0);
    row_tick(16'hFFFF, 1'b1, 8'd0);
    row_write(REG_PEAK_ALPHA, 32'd255);
    row_tick(16'd0, 1'b0, '0);
    row_write(REG_PERIOD_MS, 32'd1024);
    // position above the new period
    row_tick(16'd0, 1'b0, '0);
    row_tick(16'd97, 1'b1, 8'd255);
    row_tick(16'd256, 1'b1, 8'd127);
    row_tick(16'd256, 1'b1, 8'd0);
    row_tick(16'hFFFF, 1'b0, '0);
    // zero period is dropped
    row_write(REG_PERIOD_MS, 32'd0);
    row_tick(16'd1, 1'b1, 8'd0);
    row_write(REG_PERIOD_MS, 32'hFFFF_FFFF);
    row_tick(16'hFFFF, 1'b0, '0);
    row_write(REG_PERIOD_MS, 32'd1);
    row_tick(16'd0, 1'b1, 8'd0);
    row_tick(16'hFFFF, 1'b1, 8'd0);
    // upper data bits are masked
    row_write(REG_PEAK_ALPHA, 32'hFFFF_FF80);
    row_write(REG_PERIOD_MS, 32'd2);
    row_tick(16'd1, 1'b1, 8'd128);
    // unused register indexes
    row_write(REG_SPARE_LO, 32'd5);
    row_write(REG_SPARE_HI, 32'hFFFF_FFFF);
    row_tick(16'd1, 1'b1, 8'd0);
    row_tick(16'd1, 1'b1, 8'd128);
    row_write(REG_PERIOD_MS, 32'd1000);
    row_write(REG_PEAK_ALPHA, 32'd200);
    row_tick(16'd250, 1'b0, '0);
    row_tick(16'd123, 1'b0, '0);
    row_tick(16'hFFFF, 1'b0, '0);
    row_write(REG_PEAK_ALPHA, 32'd0);
    row_tick(16'd1, 1'b1, 8'd0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE) begin
        park_and_drain();
        write_reg(stim_table[i].idx, stim_table[i].data);
      end else begin
        send_tick(stim_table[i].elapsed, stim_table[i].known, stim_table[i].alpha);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      park_and_drain();
      write_reg(REG_PERIOD_MS, random_period());
      case ($urandom_range(0, 3))
        0: write_reg(REG_PEAK_ALPHA, '0);
        1: write_reg(REG_PEAK_ALPHA, 32'd255);
        default: write_reg(REG_PEAK_ALPHA, $urandom());
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
      sent = 0;
      while (sent < TICKS_PER_PHASE) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          send_tick(random_elapsed(), 1'b0, '0);
          sent++;
        end
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk_i);
        end
      end
    end

    in_valid <= 1'b0;
    while (alpha_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
